@@ hdl/usbs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package usbs_pkg;

  // Ones in a row after which a stuff bit goes onto the line
  localparam logic [2:0] RUN_LIMIT = 3'd6;

  // Line states are collected here before being split into byte pairs
  localparam int ACC_W = 24;

  // One input transfer as held in the input register
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_packet;
  } usbs_item_t;

  // One output byte pair
  typedef struct packed {
    logic [7:0] minus_line_byte;
    logic [7:0] plus_line_byte;
    logic       packet_done;
  } usbs_pair_t;

  // Encoder result for one item: up to three byte pairs, earliest in slot 0
  typedef struct packed {
    logic [1:0]           count;
    usbs_pair_t [2:0]     pair;
  } usbs_enc_t;

endpackage

`default_nettype wire

@@ hdl/usbs_in_reg.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usbs_in_reg (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [7:0]          in_data_byte,
  input  wire                 in_end_of_packet,
  input  wire                 load,
  output logic                item_vld,
  output usbs_pkg::usbs_item_t item
);
  import usbs_pkg::*;

  logic        vld_r, vld_nxt;
  usbs_item_t  item_r;
  logic        accept;

  // Stall while the held item is not taken by the encoder this cycle
  assign in_stall = vld_r && !load;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (load) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.data_byte     <= in_data_byte;
      item_r.end_of_packet <= in_end_of_packet;
    end
  end

  assign item_vld = vld_r;
  assign item     = item_r;

endmodule

`default_nettype wire

@@ hdl/usbs_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usbs_encoder (
  input  wire                  clk,
  input  wire                  rst_n,
  input  usbs_pkg::usbs_item_t item,
  input  wire                  load,
  output usbs_pkg::usbs_enc_t  enc
);
  import usbs_pkg::*;

  // Line and packing state carried between items
  logic       line_is_k_r, line_is_k_nxt;
  logic [2:0] ones_run_r, ones_run_nxt;
  logic [6:0] pend_m_r, pend_m_nxt;
  logic [6:0] pend_p_r, pend_p_nxt;
  logic [2:0] pend_cnt_r, pend_cnt_nxt;

  // Working values for the expansion of one item
  logic [ACC_W-1:0] acc_m, acc_p;
  logic [ACC_W-1:0] al_m, al_p;
  logic [4:0]       cnt;
  logic             k_w;
  logic [2:0]       ones_w;
  logic [2:0]       pad;
  logic [1:0]       nb;
  logic [2:0]       rem;
  logic [6:0]       rem_mask;

  // NRZI with stuffing, EOP and padding; D- and D+ levels shifted in, earliest highest
  always_comb begin
    acc_m  = {17'd0, pend_m_r};
    acc_p  = {17'd0, pend_p_r};
    cnt    = {2'd0, pend_cnt_r};
    k_w    = line_is_k_r;
    ones_w = ones_run_r;
    pad    = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (!item.data_byte[i]) begin
        // zero: toggle the line
        ones_w = 3'd0;
        k_w    = ~k_w;
        acc_m  = {acc_m[ACC_W-2:0], ~k_w};
        acc_p  = {acc_p[ACC_W-2:0], k_w};
        cnt    = cnt + 5'd1;
      end else begin
        // one: hold the line, stuff a toggle after a full run
        acc_m = {acc_m[ACC_W-2:0], ~k_w};
        acc_p = {acc_p[ACC_W-2:0], k_w};
        cnt   = cnt + 5'd1;
        if (ones_w == RUN_LIMIT - 3'd1) begin
          ones_w = 3'd0;
          k_w    = ~k_w;
          acc_m  = {acc_m[ACC_W-2:0], ~k_w};
          acc_p  = {acc_p[ACC_W-2:0], k_w};
          cnt    = cnt + 5'd1;
        end else begin
          ones_w = ones_w + 3'd1;
        end
      end
    end
    if (item.end_of_packet) begin
      // SE0, SE0, J, then J up to a byte boundary
      acc_m = {acc_m[ACC_W-4:0], 3'b001};
      acc_p = {acc_p[ACC_W-4:0], 3'b000};
      cnt   = cnt + 5'd3;
      pad   = 3'd0 - cnt[2:0];
      acc_m = (acc_m << pad) | ((24'd1 << pad) - 24'd1);
      acc_p = acc_p << pad;
      cnt   = cnt + {2'd0, pad};
    end
  end

  // Split into full byte pairs and a leftover
  assign nb       = cnt[4:3];
  assign rem      = cnt[2:0];
  assign al_m     = acc_m >> rem;
  assign al_p     = acc_p >> rem;
  assign rem_mask = 7'((8'd1 << rem) - 8'd1);

  always_comb begin
    enc       = '0;
    enc.count = nb;
    unique case (nb)
      2'd0: begin
      end
      2'd1: begin
        enc.pair[0].minus_line_byte = al_m[7:0];
        enc.pair[0].plus_line_byte  = ~al_p[7:0];
        enc.pair[0].packet_done     = item.end_of_packet;
      end
      2'd2: begin
        enc.pair[0].minus_line_byte = al_m[15:8];
        enc.pair[0].plus_line_byte  = ~al_p[15:8];
        enc.pair[1].minus_line_byte = al_m[7:0];
        enc.pair[1].plus_line_byte  = ~al_p[7:0];
        enc.pair[1].packet_done     = item.end_of_packet;
      end
      2'd3: begin
        enc.pair[0].minus_line_byte = al_m[23:16];
        enc.pair[0].plus_line_byte  = ~al_p[23:16];
        enc.pair[1].minus_line_byte = al_m[15:8];
        enc.pair[1].plus_line_byte  = ~al_p[15:8];
        enc.pair[2].minus_line_byte = al_m[7:0];
        enc.pair[2].plus_line_byte  = ~al_p[7:0];
        enc.pair[2].packet_done     = item.end_of_packet;
      end
    endcase
  end

  // State update; a packet end returns the line to idle J
  always_comb begin
    line_is_k_nxt = line_is_k_r;
    ones_run_nxt  = ones_run_r;
    pend_m_nxt    = pend_m_r;
    pend_p_nxt    = pend_p_r;
    pend_cnt_nxt  = pend_cnt_r;
    if (load) begin
      line_is_k_nxt = item.end_of_packet ? 1'b0 : k_w;
      ones_run_nxt  = item.end_of_packet ? 3'd0 : ones_w;
      pend_m_nxt    = acc_m[6:0] & rem_mask;
      pend_p_nxt    = acc_p[6:0] & rem_mask;
      pend_cnt_nxt  = rem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_is_k_r <= 1'b0;
      ones_run_r  <= 3'd0;
      pend_m_r    <= 7'd0;
      pend_p_r    <= 7'd0;
      pend_cnt_r  <= 3'd0;
    end else begin
      line_is_k_r <= line_is_k_nxt;
      ones_run_r  <= ones_run_nxt;
      pend_m_r    <= pend_m_nxt;
      pend_p_r    <= pend_p_nxt;
      pend_cnt_r  <= pend_cnt_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hdl/usbs_out_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module usbs_out_queue (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 item_vld,
  input  usbs_pkg::usbs_enc_t enc,
  output logic                load,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [7:0]          out_minus_line_byte,
  output logic [7:0]          out_plus_line_byte,
  output logic                out_packet_done
);
  import usbs_pkg::*;

  usbs_pair_t [2:0] q_r, q_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic             fire;

  assign out_valid = (cnt_r != 2'd0);
  assign fire      = out_valid && !out_stall;

  // Take a new item once the queue is empty or its last pair leaves now
  assign load = item_vld && ((cnt_r == 2'd0) || ((cnt_r == 2'd1) && fire));

  always_comb begin
    q_nxt   = q_r;
    cnt_nxt = cnt_r;
    if (load) begin
      q_nxt   = enc.pair;
      cnt_nxt = enc.count;
    end else if (fire) begin
      q_nxt[0] = q_r[1];
      q_nxt[1] = q_r[2];
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign out_minus_line_byte = q_r[0].minus_line_byte;
  assign out_plus_line_byte  = q_r[0].plus_line_byte;
  assign out_packet_done     = q_r[0].packet_done;

endmodule

`default_nettype wire

@@ hdl/usb_nrzi_bitstuff_serializer.sv @@
// USB low-speed NRZI serializer with bit stuffing. Each input transfer is one
// packet byte (sent MSB first); the block turns it into line states, inserts a
// stuff bit after six ones in a row, and on the byte flagged end_of_packet appends
// SE0, SE0, J and J padding to a byte boundary, after which the line restarts at
// idle J. Line states leave as byte pairs (D- and inverted D+, earliest in bit 7),
// one to three pairs per byte, packet_done set on the last pair of a packet.
// An accepted byte is held in the input register, then encoded and loaded into
// the three-pair output queue, which drains one pair per cycle while out_stall
// is low; the next byte enters the encoder as the queue's last pair leaves.
`timescale 1ns / 1ps
`default_nettype none

module usb_nrzi_bitstuff_serializer (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_data_byte,
  input  wire        in_end_of_packet,
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_minus_line_byte,
  output logic [7:0] out_plus_line_byte,
  output logic       out_packet_done
);
  import usbs_pkg::*;

  usbs_item_t item;
  usbs_enc_t  enc;
  logic       item_vld;
  logic       load;

  // Input register
  usbs_in_reg u_in_reg (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_end_of_packet (in_end_of_packet),
    .load             (load),
    .item_vld         (item_vld),
    .item             (item)
  );

  // NRZI, stuffing and packing with line state
  usbs_encoder u_encoder (
    .clk   (clk),
    .rst_n (rst_n),
    .item  (item),
    .load  (load),
    .enc   (enc)
  );

  // Result register queue
  usbs_out_queue u_out_queue (
    .clk                 (clk),
    .rst_n               (rst_n),
    .item_vld            (item_vld),
    .enc                 (enc),
    .load                (load),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_minus_line_byte (out_minus_line_byte),
    .out_plus_line_byte  (out_plus_line_byte),
    .out_packet_done     (out_packet_done)
  );

endmodule

`default_nettype wire
